// File: rtl/chsd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chsd_pkg
// types and constants shared by the huffman stream decoder modules
// ---------------------------------------------------------------------------
package chsd_pkg;

  localparam logic [7:0] HDR0_BYTE  = 8'hC0;
  localparam logic [7:0] HDR1_BYTE  = 8'hDE;
  localparam logic [7:0] HDR1_MASK  = 8'hFE;
  localparam logic [7:0] COUNT_EXT  = 8'd255;

  typedef enum logic [2:0] {
    KIND_SYM      = 3'd0,
    KIND_EOS      = 3'd1,
    KIND_BAD_HDR  = 3'd2,
    KIND_TRUNC    = 3'd3,
    KIND_TOO_LONG = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_HDR0,
    ST_HDR1,
    ST_SIZE,
    ST_COUNT,
    ST_EXTRA,
    ST_SYM,
    ST_BIT,
    ST_LOOK,
    ST_EMIT,
    ST_OUT,
    ST_FLUSH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_COUNT,
    OP_EXTRA,
    OP_SYM,
    OP_LOAD,
    OP_SHIFT,
    OP_LOOK,
    OP_HIT,
    OP_RESTART
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic len_at_max;
    logic table_full;
    logic no_length;
    logic sym_full;
    logic sym_last;
    logic bit_bad;
    logic hit;
    logic hit_eos;
    logic bits_done;
    logic [7:0] hit_symbol;
  } stat_t;

endpackage

// File: rtl/chsd_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chsd_datapath
// code tables, symbol memory and bit shifter of the huffman decoder
// ---------------------------------------------------------------------------
module chsd_datapath #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_SLOTS = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  chsd_pkg::cmd_t cmd,
  input  logic [7:0]     in_byte,
  output chsd_pkg::stat_t stat
);
  import chsd_pkg::*;

  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int LI = $clog2(MAX_CODE_LEN);
  localparam int TW = $clog2(SYMBOL_SLOTS + 1);
  localparam int SI = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
  localparam int CW = MAX_CODE_LEN + 1;

  logic [LW-1:0] len_r, len_nxt;
  logic [8:0]    left_r, left_nxt;
  logic [CW-1:0] next_code_r, next_code_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [MAX_CODE_LEN-1:0] part_r, part_nxt;
  logic [LW-1:0] plen_r, plen_nxt;
  logic [7:0]    shreg_r, shreg_nxt;
  logic [3:0]    bits_r, bits_nxt;

  logic [MAX_CODE_LEN-1:0] first_mem [MAX_CODE_LEN];
  logic [TW-1:0]           index_mem [MAX_CODE_LEN];
  logic [TW-1:0]           count_r   [MAX_CODE_LEN];
  logic [7:0]              sym_mem   [SYMBOL_SLOTS];

  logic [MAX_CODE_LEN-1:0] first_q_r;
  logic [TW-1:0]           index_q_r, count_q_r;
  logic [7:0]              sym_q_r;
  logic                    hit_r, hit_nxt, eos_r, eos_nxt;
  logic [TW-1:0]           idx_r, idx_nxt;

  logic [LI-1:0] wr_li, rd_li;
  logic [CW-1:0] shifted_code, len_mask;
  logic [MAX_CODE_LEN-1:0] diff;
  logic          full_now;

  assign wr_li        = LI'(len_r);
  assign rd_li        = LI'(plen_nxt - LW'(1));
  assign shifted_code = next_code_r << 1;
  assign len_mask     = (CW'(1) << len_r) - CW'(1);
  assign full_now     = (next_code_r == len_mask);
  assign diff         = part_r - first_q_r;

  always_comb begin
    len_nxt = len_r; left_nxt = left_r; next_code_nxt = next_code_r;
    total_nxt = total_r; part_nxt = part_r; plen_nxt = plen_r;
    shreg_nxt = shreg_r; bits_nxt = bits_r; hit_nxt = hit_r; eos_nxt = eos_r;
    idx_nxt = idx_r;
    unique case (cmd.op)
      OP_CLEAR: begin
        len_nxt = '0; left_nxt = '0; next_code_nxt = '0; total_nxt = '0;
        part_nxt = '0; plen_nxt = '0;
      end
      OP_COUNT: begin
        len_nxt = len_r + LW'(1);
        next_code_nxt = shifted_code;
        left_nxt = {1'b0, in_byte};
      end
      OP_EXTRA: left_nxt = 9'd255 + {1'b0, in_byte};
      OP_SYM: begin
        total_nxt = total_r + TW'(1);
        next_code_nxt = next_code_r + CW'(1);
        left_nxt = left_r - 9'd1;
        if (full_now) begin
          part_nxt = '0; plen_nxt = '0;
        end
      end
      OP_LOAD: begin
        shreg_nxt = in_byte; bits_nxt = 4'd8;
      end
      OP_SHIFT: begin
        part_nxt = {part_r[MAX_CODE_LEN-2:0], shreg_r[7]};
        plen_nxt = plen_r + LW'(1);
        shreg_nxt = {shreg_r[6:0], 1'b0};
        bits_nxt = bits_r - 4'd1;
      end
      OP_LOOK: begin
        hit_nxt = (part_r >= first_q_r) && ({{TW{1'b0}}, diff} <
                  {{MAX_CODE_LEN{1'b0}}, count_q_r});
        idx_nxt = index_q_r + TW'(diff);
        eos_nxt = (({1'b0, idx_nxt} + (TW+1)'(1)) >= {1'b0, total_r});
        if (hit_nxt) begin
          part_nxt = '0; plen_nxt = '0;
        end
      end
      OP_RESTART: begin
        part_nxt = '0; plen_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; left_r <= '0; next_code_r <= '0; total_r <= '0;
      part_r <= '0; plen_r <= '0; bits_r <= '0; hit_r <= 1'b0; eos_r <= 1'b0;
      for (int i = 0; i < MAX_CODE_LEN; i++) count_r[i] <= '0;
    end else begin
      len_r <= len_nxt; left_r <= left_nxt; next_code_r <= next_code_nxt;
      total_r <= total_nxt; part_r <= part_nxt; plen_r <= plen_nxt;
      bits_r <= bits_nxt; hit_r <= hit_nxt; eos_r <= eos_nxt;
      if (cmd.op == OP_COUNT) count_r[wr_li] <= '0;
      if (cmd.op == OP_SYM) count_r[LI'(len_r - LW'(1))] <=
          count_r[LI'(len_r - LW'(1))] + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    idx_r   <= idx_nxt;
    if (cmd.op == OP_COUNT) begin
      first_mem[wr_li] <= shifted_code[MAX_CODE_LEN-1:0];
      index_mem[wr_li] <= total_r;
    end
    if (cmd.op == OP_SYM) sym_mem[SI'(total_r)] <= in_byte;
    first_q_r <= first_mem[rd_li];
    index_q_r <= index_mem[rd_li];
    count_q_r <= count_r[rd_li];
    sym_q_r   <= sym_mem[SI'(idx_nxt)];
  end

  assign stat.len_at_max = (len_r >= LW'(MAX_CODE_LEN));
  assign stat.table_full = ({1'b0, total_r} >= (TW+1)'(SYMBOL_SLOTS));
  assign stat.no_length  = (len_r == '0);
  assign stat.sym_full   = full_now;
  assign stat.sym_last   = (left_r == 9'd1);
  assign stat.bit_bad    = (plen_r == '0) || (plen_r > len_r);
  assign stat.hit        = hit_r;
  assign stat.hit_eos    = eos_r;
  assign stat.bits_done  = (bits_r == 4'd0);
  assign stat.hit_symbol = sym_q_r;

endmodule

// File: rtl/chsd_control.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chsd_control
// sequencer for header, table build and bit-serial payload decode
// ---------------------------------------------------------------------------
module chsd_control (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  input  chsd_pkg::stat_t stat,
  output chsd_pkg::cmd_t  cmd,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_symbol,
  output logic [2:0]      out_kind,
  output logic            out_last
);
  import chsd_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic [7:0] osym_r, osym_nxt;
  kind_t  okind_r, okind_nxt;
  logic   olast_r, olast_nxt;
  logic   pv_r, pv_nxt;
  logic [7:0] psym_r, psym_nxt;
  kind_t  pkind_r, pkind_nxt;
  logic   pset, pclr;
  kind_t  pkind_in;
  logic [7:0] psym_in;
  logic   acc;
  logic   emit;
  kind_t  ekind;
  logic [7:0] esym;
  logic   elast;

  assign acc = in_tvalid && in_tready;

  // output register: can hold one result while next work waits
  assign out_tvalid = ov_r;
  assign out_symbol = osym_r;
  assign out_kind   = okind_r;
  assign out_last   = olast_r;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd.op = OP_NONE;
    emit = 1'b0; ekind = KIND_SYM; esym = 8'd0; elast = 1'b1;
    pset = 1'b0; pclr = 1'b0; pkind_in = KIND_SYM; psym_in = 8'd0;
    unique case (state_r)
      ST_HDR0, ST_HDR1, ST_SIZE, ST_COUNT, ST_EXTRA, ST_SYM, ST_OUT: begin
        in_tready = !ov_r || out_tready;
        if (acc) begin
          if (in_end) begin
            emit = 1'b1;
            ekind = (state_r == ST_OUT) ? KIND_EOS : KIND_TRUNC;
            state_nxt = ST_HDR0;
          end else begin
            unique case (state_r)
              ST_HDR0: begin
                if (in_byte != HDR0_BYTE) begin
                  emit = 1'b1; ekind = KIND_BAD_HDR;
                end else begin
                  cmd.op = OP_CLEAR; state_nxt = ST_HDR1;
                end
              end
              ST_HDR1: begin
                if ((in_byte & HDR1_MASK) != HDR1_BYTE) begin
                  emit = 1'b1; ekind = KIND_BAD_HDR; state_nxt = ST_HDR0;
                end else state_nxt = ST_SIZE;
              end
              ST_SIZE: state_nxt = ST_COUNT;
              ST_COUNT: begin
                if (stat.len_at_max) begin
                  emit = 1'b1; ekind = KIND_TOO_LONG; state_nxt = ST_HDR0;
                end else begin
                  cmd.op = OP_COUNT;
                  if (in_byte == COUNT_EXT) state_nxt = ST_EXTRA;
                  else if (in_byte != 8'd0) state_nxt = ST_SYM;
                end
              end
              ST_EXTRA: begin
                cmd.op = OP_EXTRA; state_nxt = ST_SYM;
              end
              ST_SYM: begin
                if (stat.table_full || stat.no_length) begin
                  emit = 1'b1; ekind = KIND_TOO_LONG; state_nxt = ST_HDR0;
                end else begin
                  cmd.op = OP_SYM;
                  if (stat.sym_full) state_nxt = ST_OUT;
                  else if (stat.sym_last) state_nxt = ST_COUNT;
                end
              end
              default: begin
                cmd.op = OP_LOAD; state_nxt = ST_BIT;
              end
            endcase
          end
        end
      end
      ST_BIT: begin
        if (stat.bits_done) begin
          // held symbol is the last result of this byte
          if (!pv_r) state_nxt = ST_OUT;
          else if (!ov_r || out_tready) begin
            emit = 1'b1; ekind = pkind_r; esym = psym_r; pclr = 1'b1;
            state_nxt = ST_OUT;
          end
        end else begin
          cmd.op = OP_SHIFT; state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (stat.bit_bad) begin
          cmd.op = OP_RESTART; state_nxt = ST_BIT;
        end else begin
          cmd.op = OP_LOOK; state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat.hit) state_nxt = ST_BIT;
        else if (!pv_r || !ov_r || out_tready) begin
          // a newer hit means the held symbol is not the last one
          if (pv_r) begin
            emit = 1'b1; ekind = pkind_r; esym = psym_r; elast = 1'b0;
          end
          pset = 1'b1;
          if (stat.hit_eos) begin
            pkind_in = KIND_EOS; state_nxt = ST_FLUSH;
          end else begin
            pkind_in = KIND_SYM; psym_in = stat.hit_symbol; state_nxt = ST_BIT;
          end
        end
      end
      ST_FLUSH: begin
        if (!ov_r || out_tready) begin
          emit = 1'b1; ekind = pkind_r; esym = psym_r; pclr = 1'b1;
          state_nxt = ST_HDR0;
        end
      end
      default: state_nxt = ST_HDR0;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r && !out_tready;
    osym_nxt = osym_r; okind_nxt = okind_r; olast_nxt = olast_r;
    if (emit) begin
      ov_nxt = 1'b1; osym_nxt = esym; okind_nxt = ekind; olast_nxt = elast;
    end
    pv_nxt = pv_r; psym_nxt = psym_r; pkind_nxt = pkind_r;
    if (pclr) pv_nxt = 1'b0;
    if (pset) begin
      pv_nxt = 1'b1; psym_nxt = psym_in; pkind_nxt = pkind_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HDR0;
      ov_r    <= 1'b0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      pv_r    <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    osym_r <= osym_nxt; okind_r <= okind_nxt; olast_r <= olast_nxt;
    psym_r <= psym_nxt; pkind_r <= pkind_nxt;
  end

endmodule

// File: rtl/canonical_huffman_stream_decoder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// canonical_huffman_stream_decoder_core
// Canonical huffman stream decoder: header check, table build, bit decode.
//
// in channel: one compressed byte per item, in_tuser flags source end.
// out channel: one result per item: symbol, kind and tlast on the last
// result caused by one input item.
// Header and table bytes are taken whenever the output register is free
// or being drained. A payload byte is loaded, then decoded one code bit at
// a time (shift with table read, compare against the registered
// per-length entry, emit), and closed before the next byte is taken.
// A decoded symbol is held until the next hit or the end of the byte so
// tlast can mark the last result of the byte. The output register holds
// one result; while the receiver stalls the bit walk waits before
// emitting the next result and no input is taken.
// Reset returns to waiting for the first header byte and clears the
// per-length counts; tables are rebuilt from each header.
// ---------------------------------------------------------------------------
module canonical_huffman_stream_decoder_core #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // stream_byte
  input  logic        in_tuser,   // source_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // symbol[7:0], kind[10:8], zero fill
  output logic        out_tlast
);
  import chsd_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [7:0] sym;
  logic [2:0] kind;

  chsd_datapath #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_SLOTS(SYMBOL_SLOTS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_byte(in_tdata), .stat(stat)
  );

  chsd_control u_ctl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_byte(in_tdata), .in_end(in_tuser), .stat(stat), .cmd(cmd),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_symbol(sym),
    .out_kind(kind), .out_last(out_tlast)
  );

  assign out_tdata = {5'd0, kind, sym};

endmodule

// File: rtl/chsd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chsd_checker
// port level checks of the huffman stream decoder
// ---------------------------------------------------------------------------
module chsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10:8] <= 3'd4 && out_tdata[15:11] == 5'd0)
    else $error("bad result kind");

  a_errlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10:8] != 3'd0 |-> out_tlast)
    else $error("error or end without last");

  a_errsym: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10:8] != 3'd0 |-> out_tdata[7:0] == 8'd0)
    else $error("symbol set on non-symbol result");

endmodule

bind canonical_huffman_stream_decoder_core chsd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast)
);
